// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Request and status codes, default capacity and the command that is
// broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int DATA_W       = 32;
   localparam int CAPACITY_DEF = 16;

   // request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_BADINDEX = 2'd3;

   // shift command seen by every cell in the same cycle
   typedef struct packed {
      logic ins;   // accepted insert, shift up from position
      logic rem;   // accepted remove, shift down onto position
   } cell_cmd_type;

endpackage

// ===== rtl/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell: one list slot
// Holds one word. On insert it takes its lower neighbor's word (above the
// position) or the new word (at the position); on remove it takes its upper
// neighbor's word (at or above the position). Also drives a read tap.
// ----------------------------------------------------------------------------
module pal_cell
   import pal_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int POS_W = 5
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic [POS_W-1:0]         position,
   input  logic signed [DATA_W-1:0] value,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data_ff,
   output logic signed [DATA_W-1:0] tap
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

   logic signed [DATA_W-1:0] data_in;
   logic                     at_pos;
   logic                     above_pos;

   assign at_pos    = (position == MY_IDX);
   assign above_pos = (MY_IDX > position);

   // next word for this slot
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (above_pos) begin
            data_in = left_data;
         end else if (at_pos) begin
            data_in = value;
         end
      end else if (cmd.rem) begin
         if (above_pos || at_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // read tap: word of the addressed slot, zero elsewhere
   assign tap = at_pos ? data_ff : '0;

endmodule

// ===== rtl/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl: request checks and entry count
// Decodes the request, runs the full/empty and index checks, keeps the
// entry count and issues the shift command to the cells.
// ----------------------------------------------------------------------------
module pal_ctrl
   import pal_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CNT_W    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       req_type,
   input  logic [CNT_W-1:0] position,
   output cell_cmd_type     cmd,
   output logic             rd_ok,
   output logic [1:0]       status,
   output logic [CNT_W-1:0] count_in
);

   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   logic [CNT_W-1:0] count_ff;

   // checks: full or empty first, then index
   always_comb begin
      status = ST_OK;
      cmd    = '0;
      rd_ok  = 1'b0;
      case (req_type)
         REQ_INSERT: begin
            if (count_ff >= CAP) begin
               status = ST_FULL;
            end else if (position > count_ff) begin
               status = ST_BADINDEX;
            end else begin
               cmd.ins = accept;
            end
         end
         REQ_REMOVE, REQ_READ: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (position >= count_ff) begin
               status = ST_BADINDEX;
            end else begin
               rd_ok   = 1'b1;
               cmd.rem = accept && (req_type == REQ_REMOVE);
            end
         end
         default: begin
            status = ST_BADINDEX;
         end
      endcase
   end

   // count after this item
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + ONE;
      end else if (cmd.rem) begin
         count_in = count_ff - ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + ONE)
      else $error("insert did not raise the count");

   a_rem_count: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> count_ff == $past(count_ff) - ONE)
      else $error("remove did not lower the count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("count above capacity");

endmodule

// ===== rtl/positional_array_list.sv =====
// The result strobe is registered: it rises in the cycle after the request is accepted.
// Throughput: one item per cycle; busy stays low, since every cell shifts in
// parallel in the same cycle and the next item sees the updated list.
// Reset clears the entry count and the result strobe; stored words are not
// cleared and only words below the count are ever read.
// Results are presented for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// positional_array_list: ordered list with insert/remove/read at a position
// A row of word cells shifts up on insert and down on remove; a control
// unit checks each request and keeps the count; results are registered.
// ----------------------------------------------------------------------------
module positional_array_list
   import pal_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int POS_W    = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]         rsp_count,
   output logic                     rsp_full_flag,
   output logic                     rsp_empty_flag
);

   localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

   logic                     accept;
   cell_cmd_type             cmd;
   logic                     rd_ok;
   logic [1:0]               status;
   logic [POS_W-1:0]         count_in;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
   logic signed [DATA_W-1:0] hit_word;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_read_value_ff;
   logic [POS_W-1:0]         rsp_count_ff;
   logic                     rsp_full_ff;
   logic                     rsp_empty_ff;

   // every item is taken in the cycle it arrives, so the block is never busy
   assign busy   = 1'b0;
   assign accept = start && !busy;

   pal_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (POS_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .position (req_position),
      .cmd      (cmd),
      .rd_ok    (rd_ok),
      .status   (status),
      .count_in (count_in)
   );

   // row of cells, each wired to its neighbors, with zero fed in at both ends
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      pal_cell #(
         .IDX   (i),
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .position   (req_position),
         .value      (req_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data_ff    (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   // combine read taps; only the addressed cell can be nonzero
   always_comb begin
      hit_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_word = hit_word | cell_tap[i];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_read_value_ff <= rd_ok ? hit_word : '0;
         rsp_count_ff      <= count_in;
         rsp_full_ff       <= (count_in == CAP);
         rsp_empty_ff      <= (count_in == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_full_flag  = rsp_full_ff;
   assign rsp_empty_flag = rsp_empty_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0)
      else $error("failed item returned a nonzero word");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result strobe");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_count == '0)) &&
                    (rsp_full_flag == (rsp_count == CAP)))
      else $error("flags disagree with count");

endmodule
